### sv/qrspp_pkg.sv
// ----------------------------------------------------------------------------
// qrspp_pkg
// shared constants and helpers for the qrs pre-processing filter chain
// ----------------------------------------------------------------------------
package qrspp_pkg;

  // defaults for the top-level parameters
  localparam int WINDOW_DEF      = 30;
  localparam int SAMPLE_BITS_DEF = 12;

  // datapath widths
  localparam int DATA_W = 32;  // filter stage words, wrap at 32 bits
  localparam int SQ_W   = 31;  // squared and integrated outputs
  localparam int MAG_W  = 29;  // |derivative| never exceeds 2^28

  // result transfer: lp, hp, derivative, squared, integrated
  localparam int RES_W = 3 * DATA_W + 2 * SQ_W;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - RES_W;

  // delay line depths and taps
  localparam int RAW_DEPTH = 12;
  localparam int RAW_TAP_A = 5;   // x[n-6]
  localparam int RAW_TAP_B = 11;  // x[n-12]
  localparam int LP_DEPTH  = 32;
  localparam int LP_TAP_A  = 15;  // y[n-16]
  localparam int LP_TAP_B  = 16;  // y[n-17]
  localparam int LP_TAP_C  = 31;  // y[n-32]
  localparam int HP_DEPTH  = 4;
  localparam int HP_TAP_A  = 2;   // h[n-3]
  localparam int HP_TAP_B  = 3;   // h[n-4]

  // truncating divisions by powers of two
  localparam int LP_SHIFT = 5;  // divide by 32
  localparam int DV_SHIFT = 3;  // divide by 8

  // signed divide by 2^k, rounding toward zero
  function automatic logic signed [DATA_W-1:0] tdiv_pow2(
    input logic signed [DATA_W-1:0] v,
    input int unsigned              k
  );
    logic        [DATA_W-1:0] bias;
    logic signed [DATA_W-1:0] biased;
    bias   = v[DATA_W-1] ? ((DATA_W'(1) << k) - DATA_W'(1)) : '0;
    biased = v + $signed(bias);
    return biased >>> k;
  endfunction

endpackage

### sv/qrspp_divider.sv
// ----------------------------------------------------------------------------
// qrspp_divider
// restoring unsigned divider, two quotient bits per clock
// ----------------------------------------------------------------------------
module qrspp_divider #(
  parameter int DVD_W = 36,  // must be even
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             busy
);

  localparam int STEPS  = DVD_W / 2;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  dvd_next;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  rem_next;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] left;

  // dividend shifts out at the top while quotient bits fill in at the bottom
  always_comb begin : radix4_step
    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    dvd_next = dvd;
    rem_next = rem;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_next, dvd_next[DVD_W-1]};
      diff     = trial - {1'b0, dvs};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next    = diff[DVS_W-1:0];
        dvd_next[0] = 1'b1;
      end else begin
        rem_next = trial[DVS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (start) begin
      left <= STEP_W'(STEPS);
    end else if (left != '0) begin
      left <= left - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (left != '0) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  assign busy     = (left != '0);
  assign quotient = dvd;

endmodule

### sv/qrs_preprocess_filter_chain_unit.sv
// ----------------------------------------------------------------------------
// qrs_preprocess_filter_chain_unit
// ecg qrs pre-processing: low-pass, high-pass, derivative, square, integrate
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one ecg sample per transfer, signed, in the low SAMPLE_BITS
//   bits of s_tdata. m_* channel: one result per sample carrying every
//   stage's output for that sample.
//   the block works on one sample at a time; s_tready is high only while it
//   is idle. a sample passes through the accepting step, 15 steps through
//   a single 32-bit add/subtract unit (five steps per filter stage), one
//   multiply and two window-sum updates, then the two-bit-per-cycle
//   divider that forms the window mean, before the next sample is taken.
//   the result sits in an output register, so a sample is taken while the
//   previous result still waits. if the receiver still stalls when the next
//   result is ready, the block holds in its final state until the output
//   register frees.
//   reset (rst, synchronous) clears every delay line, the window sum, the
//   fill count and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module qrs_preprocess_filter_chain_unit
  import qrspp_pkg::*;
#(
  parameter int  WINDOW      = WINDOW_DEF,
  parameter int  SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // sample
  output logic             m_tvalid,
  input  logic             m_tready,
  // lowpass_out, highpass_out, derivative_out, squared_out, integrated_out
  output logic [OUT_W-1:0] m_tdata
);

  // window sum width: WINDOW values below 2^31 each
  localparam int SUM_W = SQ_W + $clog2(WINDOW);
  localparam int DIV_W = SUM_W + (SUM_W % 2);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // sequencer: one state per use of the shared adder, plus square, window-sum and divide states
  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_LP0  = 20'h00002,
    S_LP1  = 20'h00004,
    S_LP2  = 20'h00008,
    S_LP3  = 20'h00010,
    S_LP4  = 20'h00020,
    S_HP0  = 20'h00040,
    S_HP1  = 20'h00080,
    S_HP2  = 20'h00100,
    S_HP3  = 20'h00200,
    S_HP4  = 20'h00400,
    S_DV0  = 20'h00800,
    S_DV1  = 20'h01000,
    S_DV2  = 20'h02000,
    S_DV3  = 20'h04000,
    S_DV4  = 20'h08000,
    S_SQ   = 20'h10000,
    S_WSUB = 20'h20000,
    S_WADD = 20'h40000,
    S_DIV  = 20'h80000
  } state_t;

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  state_t  state;
  state_t  state_next;
  alu_op_t alu_op;

  logic signed [DATA_W-1:0] operand;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W-1:0] acc_next;
  logic signed [DATA_W-1:0] lp_r;
  logic signed [DATA_W-1:0] hp_r;
  logic [SAMPLE_BITS-1:0]   x_r;

  // delay lines, shifted once per sample
  logic [SAMPLE_BITS-1:0]   raw_hist [RAW_DEPTH];
  logic signed [DATA_W-1:0] lp_hist  [LP_DEPTH];
  logic signed [DATA_W-1:0] hp_hist  [HP_DEPTH];

  // squaring
  logic [DATA_W-1:0]  acc_neg;
  logic [MAG_W-1:0]   mag;
  logic [2*MAG_W-1:0] prod;
  logic [SQ_W-1:0]    sq_sat;
  logic [SQ_W-1:0]    sq_r;

  // moving window
  logic [SQ_W-1:0]  sq_mem [WINDOW];
  logic [SQ_W-1:0]  old_q;
  logic [SQ_W-1:0]  old_val;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic [PTR_W-1:0] pos;
  logic             full;

  // divider hookup
  logic             div_start;
  logic             div_busy;
  logic [DIV_W-1:0] div_quot;

  // output register
  logic                     out_load;
  logic signed [DATA_W-1:0] out_lp;
  logic signed [DATA_W-1:0] out_hp;
  logic signed [DATA_W-1:0] out_d;
  logic [SQ_W-1:0]          out_sq;
  logic [SQ_W-1:0]          out_int;

  function automatic logic signed [DATA_W-1:0] widen(input logic [SAMPLE_BITS-1:0] s);
    return {{(DATA_W - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
  endfunction

  assign s_tready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // sequencer and operand selection for the shared adder
  //   low-pass : y  = 2*y1 - y2 + (x - 2*x6 + x12)/32
  //   high-pass: h  = h1 - y/32 + y16 - y17 + y32/32
  //   deriv    : d  = (2*h + h1 - h3 - 2*h4)/8
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    alu_op     = ALU_HOLD;
    operand    = acc;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          alu_op     = ALU_LOAD;
          operand    = widen(s_tdata[SAMPLE_BITS-1:0]);
          state_next = S_LP0;
        end
      end
      S_LP0: begin
        alu_op     = ALU_SUB;
        operand    = widen(raw_hist[RAW_TAP_A]) <<< 1;
        state_next = S_LP1;
      end
      S_LP1: begin
        alu_op     = ALU_ADD;
        operand    = widen(raw_hist[RAW_TAP_B]);
        state_next = S_LP2;
      end
      S_LP2: begin
        alu_op     = ALU_LOAD;
        operand    = tdiv_pow2(acc, LP_SHIFT);
        state_next = S_LP3;
      end
      S_LP3: begin
        alu_op     = ALU_ADD;
        operand    = lp_hist[0] <<< 1;
        state_next = S_LP4;
      end
      S_LP4: begin
        alu_op     = ALU_SUB;
        operand    = lp_hist[1];
        state_next = S_HP0;
      end
      S_HP0: begin
        alu_op     = ALU_LOAD;
        operand    = hp_hist[0];
        state_next = S_HP1;
      end
      S_HP1: begin
        alu_op     = ALU_SUB;
        operand    = tdiv_pow2(lp_r, LP_SHIFT);
        state_next = S_HP2;
      end
      S_HP2: begin
        alu_op     = ALU_ADD;
        operand    = lp_hist[LP_TAP_A];
        state_next = S_HP3;
      end
      S_HP3: begin
        alu_op     = ALU_SUB;
        operand    = lp_hist[LP_TAP_B];
        state_next = S_HP4;
      end
      S_HP4: begin
        alu_op     = ALU_ADD;
        operand    = tdiv_pow2(lp_hist[LP_TAP_C], LP_SHIFT);
        state_next = S_DV0;
      end
      S_DV0: begin
        alu_op     = ALU_LOAD;
        operand    = hp_r <<< 1;
        state_next = S_DV1;
      end
      S_DV1: begin
        alu_op     = ALU_ADD;
        operand    = hp_hist[0];
        state_next = S_DV2;
      end
      S_DV2: begin
        alu_op     = ALU_SUB;
        operand    = hp_hist[HP_TAP_A];
        state_next = S_DV3;
      end
      S_DV3: begin
        alu_op     = ALU_SUB;
        operand    = hp_hist[HP_TAP_B] <<< 1;
        state_next = S_DV4;
      end
      S_DV4: begin
        alu_op     = ALU_LOAD;
        operand    = tdiv_pow2(acc, DV_SHIFT);
        state_next = S_SQ;
      end
      S_SQ:   state_next = S_WSUB;
      S_WSUB: state_next = S_WADD;
      S_WADD: state_next = S_DIV;
      S_DIV: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // the shared 32-bit adder, wraps naturally
  always_comb begin
    unique case (alu_op)
      ALU_LOAD: acc_next = operand;
      ALU_ADD:  acc_next = acc + operand;
      ALU_SUB:  acc_next = acc - operand;
      default:  acc_next = acc;
    endcase
  end

  // squaring: derivative sits in acc from the square step onwards
  assign acc_neg = -acc;
  assign mag     = acc[DATA_W-1] ? acc_neg[MAG_W-1:0] : acc[MAG_W-1:0];
  assign prod    = mag * mag;
  assign sq_sat  = (|prod[2*MAG_W-1:SQ_W]) ? '1 : prod[SQ_W-1:0];

  // window bookkeeping; an entry's value is only used once the window has filled
  assign full      = (count == CNT_W'(WINDOW));
  assign old_val   = full ? old_q : '0;
  assign count_inc = full ? count : count + CNT_W'(1);
  assign sum_add   = sum + SUM_W'(sq_r);

  assign div_start = (state == S_WADD);
  assign out_load  = (state == S_DIV) && !div_busy && (!m_tvalid || m_tready);

  qrspp_divider #(
    .DVD_W (DIV_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_W'(sum_add)),
    .divisor  (count_inc),
    .quotient (div_quot),
    .busy     (div_busy)
  );

  // control state, delay lines, window bookkeeping and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      raw_hist <= '{default: '0};
      lp_hist  <= '{default: '0};
      hp_hist  <= '{default: '0};
      sum      <= '0;
      count    <= '0;
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SQ) begin
        for (int i = RAW_DEPTH - 1; i > 0; i--) raw_hist[i] <= raw_hist[i-1];
        for (int i = LP_DEPTH - 1; i > 0; i--) lp_hist[i] <= lp_hist[i-1];
        for (int i = HP_DEPTH - 1; i > 0; i--) hp_hist[i] <= hp_hist[i-1];
        raw_hist[0] <= x_r;
        lp_hist[0]  <= lp_r;
        hp_hist[0]  <= hp_r;
      end
      if (state == S_WSUB) begin
        sum <= sum - SUM_W'(old_val);
      end
      if (state == S_WADD) begin
        sum   <= sum_add;
        count <= count_inc;
        pos   <= (pos == PTR_W'(WINDOW - 1)) ? '0 : pos + PTR_W'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (s_tvalid && s_tready) x_r <= s_tdata[SAMPLE_BITS-1:0];
    if (state == S_LP4) lp_r <= acc_next;
    if (state == S_HP4) hp_r <= acc_next;
    if (state == S_SQ)  sq_r <= sq_sat;
    if (out_load) begin
      out_lp  <= lp_r;
      out_hp  <= hp_r;
      out_d   <= acc;
      out_sq  <= sq_r;
      out_int <= div_quot[SQ_W-1:0];
    end
  end

  // squared-value window store, one read and one write port
  always_ff @(posedge clk) begin
    if (state == S_DV0) old_q <= sq_mem[pos];
    if (state == S_WADD) sq_mem[pos] <= sq_r;
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_int, out_sq, out_d, out_hp, out_lp};

endmodule

### sv/qrspp_checker.sv
// ----------------------------------------------------------------------------
// qrspp_checker
// port-level checks on the qrs pre-processing filter chain
// ----------------------------------------------------------------------------
module qrspp_checker
  import qrspp_pkg::*;
#(
  parameter int IN_W = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // one sample in flight: no second transfer straight after the first
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is being worked on");

  // reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("stalled result changed");

  // a waiting sample that stays valid keeps its data until it is taken
  a_in_stable: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> !s_tvalid || $stable(s_tdata))
    else $error("waiting sample changed");

endmodule

bind qrs_preprocess_filter_chain_unit qrspp_checker #(
  .IN_W (IN_W)
) u_qrspp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
